### design/vrrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrrm_pkg
// Types, widths and codes shared by the variable record ring manager.
// ----------------------------------------------------------------------------
package vrrm_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_RECORDS  = 64;

  localparam int POS_W   = $clog2(BUFFER_BYTES + 1);  // byte position incl. end
  localparam int ADDR_W  = 12;                         // address output field
  localparam int LEN_W   = 13;                         // length fields
  localparam int SIZE_W  = LEN_W + 1;                  // add_size + append_size
  localparam int SUM_W   = SIZE_W + 1;                 // position + size
  localparam int SLOT_W  = $clog2(MAX_RECORDS);
  localparam int COUNT_W = $clog2(MAX_RECORDS + 1);
  localparam int KIND_W  = 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_LIMIT_ENABLE = 1'b0;
  localparam logic REG_MAX_RECORD   = 1'b1;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_GET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_OVER_LIM = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_GOT      = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_DROPPED  = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic [1:0]        func;
    logic [LEN_W-1:0]  add_size;
    logic              append_present;
    logic [LEN_W-1:0]  append_size;
    logic [KIND_W-1:0] data_kind;
    logic [LEN_W-1:0]  read_limit;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [KIND_W-1:0] kind;
  } rsp_t;

  // one descriptor FIFO entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [KIND_W-1:0] kind;
  } desc_t;

endpackage
`default_nettype wire

### design/variable_record_ring_manager.sv
`timescale 1ns / 1ps
`default_nettype none
// A request goes through the request register, then the response register.
// Throughput: one request per cycle while rsp_stall lets the output flow, add,
// get and clear alike; the pointer update and the descriptor FIFO read never
// hold a request back. Reset (rst, synchronous) empties the ring and sets
// limit_enable=1, max_record_bytes=4096; no clearing pass is needed.
// ----------------------------------------------------------------------------
// variable_record_ring_manager
// Space manager for a byte ring of contiguous variable-length records, with a
// length/kind descriptor FIFO in place of in-buffer headers.
// ----------------------------------------------------------------------------
module variable_record_ring_manager (
  input  wire                              clk,
  input  wire                              rst,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [vrrm_pkg::APB_AW-1:0]      paddr,
  input  wire  [vrrm_pkg::APB_DW-1:0]      pwdata,
  output logic [vrrm_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  // request channel
  input  wire                              req_valid,
  output logic                             req_stall,
  input  vrrm_pkg::req_t                   req,
  // response channel
  output logic                             rsp_valid,
  input  wire                              rsp_stall,
  output vrrm_pkg::rsp_t                   rsp
);
  import vrrm_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Register index is paddr[2]; low bits ignored.
  // --------------------------------------------------------------------------
  logic             limit_enable;
  logic [LEN_W-1:0] max_record_bytes;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable     <= 1'b1;
      max_record_bytes <= LEN_W'(BUFFER_BYTES);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LIMIT_ENABLE: limit_enable     <= pwdata[0];
        REG_MAX_RECORD:   max_record_bytes <= pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_LIMIT_ENABLE: prdata[0]         = limit_enable;
      REG_MAX_RECORD:   prdata[LEN_W-1:0] = max_record_bytes;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request register. It moves on whenever the response register is free,
  // so a request can transfer every cycle while the output keeps flowing.
  // --------------------------------------------------------------------------
  logic q_valid;
  req_t q;
  logic out_free;
  logic advance;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = q_valid && out_free;
  assign req_stall = q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!req_stall) begin
      q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      q <= req;
    end
  end

  // --------------------------------------------------------------------------
  // Ring state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]   write_pos, write_pos_next;
  logic [POS_W-1:0]   wrap_end, wrap_end_next;
  logic [POS_W-1:0]   read_pos, read_pos_next;
  logic [POS_W-1:0]   used_bytes, used_bytes_next;
  logic [SLOT_W-1:0]  record_head, record_head_next;
  logic [SLOT_W-1:0]  record_tail, record_tail_next;
  logic [COUNT_W-1:0] record_count, record_count_next;

  // --------------------------------------------------------------------------
  // Descriptor FIFO memory. The read port always looks at the head the next
  // cycle will use; a same-cycle write to that slot is bypassed.
  // --------------------------------------------------------------------------
  desc_t              desc_mem [MAX_RECORDS];
  logic               mem_we;
  desc_t              mem_wdata;
  desc_t              rd_q;
  desc_t              byp_data;
  logic               byp;
  desc_t              head_desc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      desc_mem[record_tail] <= mem_wdata;
    end
    rd_q     <= desc_mem[record_head_next];
    byp      <= mem_we && (record_tail == record_head_next);
    byp_data <= mem_wdata;
  end

  assign head_desc = byp ? byp_data : rd_q;

  // --------------------------------------------------------------------------
  // Request processing
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] size;
  logic [SUM_W-1:0]  used_sum;
  logic [SUM_W-1:0]  wp_sum;
  logic [POS_W-1:0]  wp;
  logic [POS_W-1:0]  wrap_base;
  logic [POS_W-1:0]  new_wp;
  logic              place_fail;
  logic [POS_W-1:0]  rp_eff;
  rsp_t              result;

  always_comb begin
    size = {1'b0, q.add_size}
         + (q.append_present ? {1'b0, q.append_size} : SIZE_W'(0));
    used_sum = SUM_W'(used_bytes) + SUM_W'(size);
    wp_sum   = SUM_W'(write_pos) + SUM_W'(size);

    write_pos_next    = write_pos;
    wrap_end_next     = wrap_end;
    read_pos_next     = read_pos;
    used_bytes_next   = used_bytes;
    record_head_next  = record_head;
    record_tail_next  = record_tail;
    record_count_next = record_count;
    mem_we            = 1'b0;
    mem_wdata.len     = q.add_size;
    mem_wdata.kind    = q.data_kind;
    result            = '0;
    result.status     = ST_NO_SPACE;

    // placement: contiguous room, wrap to 0 when the tail end is too short
    wp         = write_pos;
    place_fail = 1'b0;
    if (write_pos == wrap_end && wp_sum > SUM_W'(BUFFER_BYTES)) begin
      if (SIZE_W'(read_pos) >= size) begin
        wp = '0;
      end else begin
        place_fail = 1'b1;
      end
    end else if (write_pos < wrap_end && wp_sum > SUM_W'(read_pos)) begin
      place_fail = 1'b1;
    end
    // failed placement on an empty ring restarts at 0
    wrap_base = place_fail ? '0 : wrap_end;
    if (place_fail) begin
      wp = '0;
    end
    new_wp = POS_W'(SUM_W'(wp) + SUM_W'(size));

    // get: jump back at the wrap-end mark
    rp_eff = (read_pos == wrap_end) ? '0 : read_pos;

    if (advance) begin
      unique case (q.func)
        FUNC_ADD: begin
          priority if (limit_enable && size > SIZE_W'(max_record_bytes)) begin
            result.status = ST_OVER_LIM;
          end else if (record_count >= COUNT_W'(MAX_RECORDS)
                       || used_sum > SUM_W'(BUFFER_BYTES)) begin
            result.status = ST_NO_SPACE;
          end else if (place_fail && used_bytes != '0) begin
            result.status = ST_NO_SPACE;
          end else begin
            mem_we            = 1'b1;
            mem_wdata.len     = LEN_W'(size);
            record_tail_next  = (record_tail == SLOT_W'(MAX_RECORDS - 1))
                              ? '0 : record_tail + 1'b1;
            record_count_next = record_count + 1'b1;
            write_pos_next    = new_wp;
            used_bytes_next   = POS_W'(SUM_W'(used_bytes) + SUM_W'(size));
            wrap_end_next     = (new_wp > wrap_base) ? new_wp : wrap_base;
            if (place_fail) begin
              read_pos_next = '0;
            end
            result.status  = ST_ADDED;
            result.address = wp[ADDR_W-1:0];
            result.length  = LEN_W'(size);
          end
        end
        FUNC_GET: begin
          if (record_count == '0) begin
            result.status = ST_EMPTY;
          end else begin
            if (read_pos == wrap_end) begin
              wrap_end_next = write_pos;
            end
            record_head_next  = (record_head == SLOT_W'(MAX_RECORDS - 1))
                              ? '0 : record_head + 1'b1;
            record_count_next = record_count - 1'b1;
            read_pos_next     = POS_W'(rp_eff + POS_W'(head_desc.len));
            used_bytes_next   = (POS_W'(head_desc.len) > used_bytes)
                              ? '0 : used_bytes - POS_W'(head_desc.len);
            result.address    = rp_eff[ADDR_W-1:0];
            result.kind       = head_desc.kind;
            if (head_desc.len > q.read_limit) begin
              result.status = ST_DROPPED;
            end else begin
              result.status = ST_GOT;
              result.length = head_desc.len;
            end
          end
        end
        FUNC_CLEAR: begin
          write_pos_next    = '0;
          wrap_end_next     = '0;
          read_pos_next     = '0;
          used_bytes_next   = '0;
          record_head_next  = '0;
          record_tail_next  = '0;
          record_count_next = '0;
          result.status     = ST_CLEARED;
        end
        default: begin
          result.status = ST_NO_SPACE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      wrap_end     <= '0;
      read_pos     <= '0;
      used_bytes   <= '0;
      record_head  <= '0;
      record_tail  <= '0;
      record_count <= '0;
    end else begin
      write_pos    <= write_pos_next;
      wrap_end     <= wrap_end_next;
      read_pos     <= read_pos_next;
      used_bytes   <= used_bytes_next;
      record_head  <= record_head_next;
      record_tail  <= record_tail_next;
      record_count <= record_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Response register; loads whenever the previous transfer has gone out.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule
`default_nettype wire

### tb/vrrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrm_checker
// Watches the request, response and register ports of the ring manager. It
// keeps its own copy of the ring pointers and descriptor FIFO and checks each
// response field by field.
// ----------------------------------------------------------------------------
module vrrm_checker (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [vrrm_pkg::APB_AW-1:0] paddr,
  input  wire  [vrrm_pkg::APB_DW-1:0] pwdata,
  input  wire                         pready,
  input  wire                         req_valid,
  input  wire                         req_stall,
  input  vrrm_pkg::req_t              req,
  input  wire                         rsp_valid,
  input  wire                         rsp_stall,
  input  vrrm_pkg::rsp_t              rsp,
  output int                          mismatches = 0,
  output int                          pending = 0,
  output int                          checked = 0
);
  import vrrm_pkg::*;

  logic               lim_en;
  logic [LEN_W-1:0]   lim_bytes;
  logic [POS_W-1:0]   wr_pos, wrap_pos, rd_pos, fill_bytes;
  logic [LEN_W-1:0]   len_fifo  [MAX_RECORDS];
  logic [KIND_W-1:0]  kind_fifo [MAX_RECORDS];
  logic [SLOT_W-1:0]  head_slot, tail_slot;
  logic [COUNT_W-1:0] rec_count;
  rsp_t               expected_rsp[$];
  rsp_t               want;

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    return (int'(s) + 1 >= MAX_RECORDS) ? '0 : s + 1'b1;
  endfunction

  function automatic void empty_ring();
    wr_pos     = '0;
    wrap_pos   = '0;
    rd_pos     = '0;
    fill_bytes = '0;
    head_slot  = '0;
    tail_slot  = '0;
    rec_count  = '0;
  endfunction

  // add: limit, then totals, then contiguous room
  function automatic rsp_t place_record(input req_t r);
    logic [SIZE_W-1:0] sz;
    logic [SUM_W-1:0]  wp;
    logic              blocked;
    rsp_t              o;
    o        = '0;
    o.status = ST_NO_SPACE;
    sz = SIZE_W'(r.add_size) + (r.append_present ? SIZE_W'(r.append_size) : '0);
    wp = SUM_W'(wr_pos);
    blocked = 1'b0;
    if (lim_en && sz > lim_bytes) begin
      o.status = ST_OVER_LIM;
      return o;
    end
    if (rec_count >= MAX_RECORDS || SUM_W'(fill_bytes) + sz > BUFFER_BYTES)
      return o;
    if (wr_pos == wrap_pos && wp + sz > BUFFER_BYTES) begin
      if (rd_pos >= sz) wp = '0;
      else blocked = 1'b1;
    end else if (wr_pos < wrap_pos && wp + sz > rd_pos) begin
      blocked = 1'b1;
    end
    if (blocked) begin
      if (fill_bytes != 0) return o;
      // nothing live in the ring: restart the read, write and wrap positions at zero
      wrap_pos = '0;
      rd_pos   = '0;
      wp       = '0;
    end
    len_fifo[tail_slot]  = LEN_W'(sz);
    kind_fifo[tail_slot] = r.data_kind;
    tail_slot  = slot_after(tail_slot);
    rec_count  = rec_count + 1'b1;
    wr_pos     = POS_W'(wp + sz);
    fill_bytes = fill_bytes + POS_W'(sz);
    if (wr_pos > wrap_pos) wrap_pos = wr_pos;
    o.status  = ST_ADDED;
    o.address = ADDR_W'(wp);
    o.length  = LEN_W'(sz);
    return o;
  endfunction

  function automatic rsp_t fetch_record(input req_t r);
    logic [LEN_W-1:0] len;
    rsp_t             o;
    o = '0;
    if (rec_count == 0) begin
      o.status = ST_EMPTY;
      return o;
    end
    if (rd_pos == wrap_pos) begin
      rd_pos   = '0;
      wrap_pos = wr_pos;
    end
    len       = len_fifo[head_slot];
    o.kind    = kind_fifo[head_slot];
    o.address = ADDR_W'(rd_pos);
    head_slot  = slot_after(head_slot);
    rec_count  = rec_count - 1'b1;
    rd_pos     = rd_pos + POS_W'(len);
    fill_bytes = (len > fill_bytes) ? '0 : fill_bytes - POS_W'(len);
    if (len > r.read_limit) begin
      o.status = ST_DROPPED;
    end else begin
      o.status = ST_GOT;
      o.length = len;
    end
    return o;
  endfunction

  function automatic rsp_t ring_response(input req_t r);
    rsp_t o;
    o        = '0;
    o.status = ST_NO_SPACE;
    case (r.func)
      FUNC_ADD:   o = place_record(r);
      FUNC_GET:   o = fetch_record(r);
      FUNC_CLEAR: begin
        empty_ring();
        o.status = ST_CLEARED;
      end
      default: ;  // unused code: no state change
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lim_en    = 1'b1;
      lim_bytes = LEN_W'(BUFFER_BYTES);
      empty_ring();
      expected_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        checked++;
        if (expected_rsp.size() == 0) begin
          mismatches++;
          $display({"%0t: expected no response, got status %0d addr %0h",
                    " len %0d kind %0h"},
                   $time, rsp.status, rsp.address, rsp.length, rsp.kind);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status || rsp.address !== want.address ||
              rsp.length !== want.length || rsp.kind !== want.kind) begin
            mismatches++;
            $display({"%0t: expected status %0d addr %0h len %0d kind %0h,",
                      " got status %0d addr %0h len %0d kind %0h"},
                     $time, want.status, want.address, want.length, want.kind,
                     rsp.status, rsp.address, rsp.length, rsp.kind);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_LIMIT_ENABLE: lim_en    = pwdata[0];
          REG_MAX_RECORD:   lim_bytes = pwdata[LEN_W-1:0];
        endcase
      end
      if (req_valid && !req_stall)
        expected_rsp.push_back(ring_response(req));
    end
    pending <= expected_rsp.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Ring manager testbench: directed adds, gets, wraps and clears, then random
// record traffic under four flow-control mixes and several limit settings.
// ----------------------------------------------------------------------------
module tb;
  import vrrm_pkg::*;

  // func code 3 has no meaning; the block must answer no-space, change nothing
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0] LEN_ALL = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;

  int mismatches, pending, checked;
  int send_gap_pct = 0;   // chance of an idle cycle before each request
  int stall_pct    = 0;   // chance of a stall cycle on the response side
  int items_sent   = 0;
  int directed_items;
  int drain_cycles;

  always #5 clk = ~clk;

  variable_record_ring_manager dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  vrrm_checker ring_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .mismatches, .pending, .checked
  );

  // response-side backpressure, redrawn every cycle
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off new requests until every response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_limits(input logic en, input logic [LEN_W-1:0] bytes);
    wait_drained();
    write_reg(REG_LIMIT_ENABLE, APB_DW'(en));
    write_reg(REG_MAX_RECORD, APB_DW'(bytes));
  endtask

  // one request transfer; random idle cycles ahead of it
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry random bits so every input bit toggles
  function automatic req_t add_req(input logic [LEN_W-1:0] head, input logic app,
                                   input logic [LEN_W-1:0] tail,
                                   input logic [KIND_W-1:0] kd);
    req_t r;
    r.func           = FUNC_ADD;
    r.add_size       = head;
    r.append_present = app;
    r.append_size    = tail;
    r.data_kind      = kd;
    r.read_limit     = LEN_W'($urandom);
    return r;
  endfunction

  function automatic req_t get_req(input logic [LEN_W-1:0] lim);
    req_t r;
    r            = req_t'({$urandom, $urandom});
    r.func       = FUNC_GET;
    r.read_limit = lim;
    return r;
  endfunction

  function automatic req_t code_req(input logic [1:0] f);
    req_t r;
    r      = req_t'({$urandom, $urandom});
    r.func = f;
    return r;
  endfunction

  // mostly mid-size records, some up to a full ring, a few with any 13-bit size
  function automatic logic [LEN_W-1:0] pick_size();
    int s;
    s = $urandom_range(99);
    if (s < 50) return LEN_W'($urandom_range(0, 600));
    if (s < 80) return LEN_W'($urandom_range(0, 2000));
    if (s < 92) return LEN_W'($urandom_range(0, BUFFER_BYTES));
    return LEN_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_read_limit();
    int s;
    s = $urandom_range(99);
    if (s < 70) return LEN_ALL;
    if (s < 85) return LEN_W'($urandom_range(0, BUFFER_BYTES));
    return LEN_W'($urandom);
  endfunction

  // burst flavors: fill the descriptor FIFO, drain the ring, or mixed traffic
  function automatic req_t random_req(input int flavor);
    int s;
    s = $urandom_range(99);
    if (flavor < 15) begin
      if (s < 80)
        return add_req(LEN_W'($urandom_range(0, 64)), 1'b0, LEN_W'($urandom), 16'($urandom));
      return add_req(LEN_W'($urandom_range(0, 32)), 1'b1, LEN_W'($urandom_range(0, 32)),
                     16'($urandom));
    end
    if (flavor < 30) return get_req(pick_read_limit());
    if (s < 2) return code_req(FUNC_CLEAR);
    if (s < 4) return code_req(FUNC_UNUSED);
    if (s < 52) begin
      if ($urandom_range(99) < 30)
        return add_req(pick_size(), 1'b1, pick_size(), 16'($urandom));
      return add_req(pick_size(), 1'b0, LEN_W'($urandom), 16'($urandom));
    end
    return get_req(pick_read_limit());
  endfunction

  task automatic run_random(input int n);
    int sent;
    int flavor;
    int burst;
    sent = 0;
    while (sent < n) begin
      flavor = $urandom_range(99);
      burst  = $urandom_range(4, 40);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_req(random_req(flavor));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, noise, zero-length and full-ring records
    set_limits(1'b1, LEN_W'(BUFFER_BYTES));
    send_req(get_req('0));                            // empty
    send_req(req_t'('1));                             // unused code, all bits set
    send_req(add_req('0, 1'b0, '0, 16'hFFFF));        // zero-length record
    send_req(get_req('0));                            // fetched with length 0
    send_req(add_req(LEN_ALL, 1'b1, LEN_ALL, '0));    // over the limit
    send_req(add_req(13'd4096, 1'b0, LEN_ALL, 16'h1234)); // fills the ring, tail ignored
    send_req(add_req('0, 1'b0, '0, 16'h0001));        // zero bytes at the very end
    send_req(add_req(13'd1, 1'b0, '0, '0));           // no space
    send_req(get_req(13'd4095));                      // too big for reader: dropped
    send_req(get_req('0));
    send_req(code_req(FUNC_CLEAR));
    // wrap: third record lands at 0, later one overruns the reader
    send_req(add_req(13'd2000, 1'b1, 13'd1000, 16'hA000));
    send_req(add_req(13'd1000, 1'b0, '0, 16'hA001));
    send_req(get_req(LEN_ALL));
    send_req(add_req(13'd500, 1'b0, '0, 16'hA002));   // jumps back to address 0
    send_req(add_req(13'd2600, 1'b0, '0, 16'hA003));  // would overrun read position
    send_req(add_req(13'd2500, 1'b0, '0, 16'hA004));
    send_req(get_req(LEN_ALL));
    send_req(get_req(LEN_ALL));                       // reader follows the wrap mark
    send_req(get_req(LEN_ALL));
    send_req(get_req(LEN_ALL));                       // empty again
    // no contiguous room but nothing live: pointers restart at 0
    send_req(add_req(13'd4000, 1'b0, '0, 16'hB000));
    send_req(get_req(LEN_ALL));
    send_req(add_req(13'd4090, 1'b0, '0, 16'hB001));
    send_req(code_req(FUNC_CLEAR));
    set_limits(1'b1, '0);
    send_req(add_req('0, 1'b0, '0, 16'hC000));        // zero fits a zero limit
    send_req(add_req('0, 1'b1, 13'd1, 16'hC001));     // one byte does not
    set_limits(1'b0, '0);
    send_req(add_req(13'd4096, 1'b1, 13'd4095, 16'hC002)); // limit off, still too big
    directed_items = items_sent;

    // random phases, each with its own flow-control mix and limit setting
    set_limits(1'b1, LEN_ALL);
    send_gap_pct = 0;  stall_pct = 0;
    run_random(175);

    set_limits(1'b0, LEN_W'(BUFFER_BYTES));
    send_gap_pct = 45; stall_pct = 0;
    run_random(90);
    wait_drained();     // let the block run completely dry mid-phase
    run_random(85);

    set_limits(1'b1, 13'd1500);
    send_gap_pct = 0;  stall_pct = 45;
    run_random(175);

    set_limits(1'b1, LEN_W'(BUFFER_BYTES));
    send_gap_pct = 26; stall_pct = 26;
    run_random(175);

    // drain, bounded, then let anything stray arrive
    req_valid <= 1'b0;
    drain_cycles = 0;
    @(posedge clk);
    while (pending != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d requests (%0d directed) over four flow-control mixes",
             items_sent, directed_items);
    $display("and six limit settings; %0d responses checked, %0d still owed",
             checked, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
